/* hw/rtl/vps_pkg.sv */
// Shared types, register codes and defaults for the vortex particle step pipeline.
`default_nettype none

package vps_pkg;

    // Default screen size in pixels
    localparam int DISP_W_DEF = 1920;
    localparam int DISP_H_DEF = 1000;

    // Configuration port geometry
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 28;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_MODE           = 3'd0;
    localparam logic [CFG_AW-1:0] REG_VORTEX_X       = 3'd1;
    localparam logic [CFG_AW-1:0] REG_VORTEX_Y       = 3'd2;
    localparam logic [CFG_AW-1:0] REG_STEP_SCALE     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DAMPING_FACTOR = 3'd4;
    localparam logic [CFG_AW-1:0] REG_ORBITAL_GAIN   = 3'd5;
    localparam logic [CFG_AW-1:0] REG_ATTRACT_GAIN   = 3'd6;

    // Mode bit positions
    localparam int MODE_ATTRACT = 0;
    localparam int MODE_WRAP    = 1;

    // Register reset values
    localparam logic [1:0]  RST_MODE           = 2'd0;
    localparam logic [27:0] RST_VORTEX_X       = 28'd62914560;
    localparam logic [27:0] RST_VORTEX_Y       = 28'd32768000;
    localparam logic [17:0] RST_STEP_SCALE     = 18'd65536;
    localparam logic [16:0] RST_DAMPING_FACTOR = 17'd65405;
    localparam logic [21:0] RST_ORBITAL_GAIN   = 22'd655360;
    localparam logic [19:0] RST_ATTRACT_GAIN   = 20'd196608;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               last_in;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               last_out;
    } t_out;

    typedef struct packed {
        logic [1:0]  mode;
        logic [27:0] vortex_x;
        logic [27:0] vortex_y;
        logic [17:0] step_scale;
        logic [16:0] damping_factor;
        logic [21:0] orbital_gain;
        logic [19:0] attract_gain;
    } t_cfg;

    // Carried alongside the square root
    typedef struct packed {
        t_in         item;
        logic [31:0] mx;
        logic [31:0] my;
        logic        sgx;
        logic        sgy;
    } t_sq_side;

    // Carried alongside the dividers
    typedef struct packed {
        t_in  item;
        logic sgx;
        logic sgy;
    } t_dv_side;

    // Unit vector and inverse distance
    typedef struct packed {
        t_in                item;
        logic signed [17:0] ux;
        logic signed [17:0] uy;
        logic [32:0]        inv;
    } t_unit;

    // Velocity plus acceleration, before damping
    typedef struct packed {
        t_in                item;
        logic signed [32:0] sum_x;
        logic signed [32:0] sum_y;
    } t_acc;

endpackage

`default_nettype wire

/* hw/rtl/vortex_particle_step.sv */
// Top level of the vortex particle step pipeline with its configuration registers.
// Pipeline stages: 3 setup, 32 square root, 35 divide, 5 force and 7 integration.
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// Reset (synchronous, active low) clears all stage valid bits and loads register defaults.
`default_nettype none

module vortex_particle_step #(
    parameter int DISP_W = vps_pkg::DISP_W_DEF,
    parameter int DISP_H = vps_pkg::DISP_H_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  vps_pkg::t_in                i_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output vps_pkg::t_out               o_out,
    input  logic                        i_cfg_we,
    input  logic [vps_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  logic [vps_pkg::CFG_DW-1:0]  i_cfg_data
);
    import vps_pkg::*;

    t_cfg r_cfg;
    logic adv;

    // Hold every stage while the output request waits
    assign adv     = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= RST_MODE;
            r_cfg.vortex_x       <= RST_VORTEX_X;
            r_cfg.vortex_y       <= RST_VORTEX_Y;
            r_cfg.step_scale     <= RST_STEP_SCALE;
            r_cfg.damping_factor <= RST_DAMPING_FACTOR;
            r_cfg.orbital_gain   <= RST_ORBITAL_GAIN;
            r_cfg.attract_gain   <= RST_ATTRACT_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:           r_cfg.mode           <= i_cfg_data[1:0];
                REG_VORTEX_X:       r_cfg.vortex_x       <= i_cfg_data[27:0];
                REG_VORTEX_Y:       r_cfg.vortex_y       <= i_cfg_data[27:0];
                REG_STEP_SCALE:     r_cfg.step_scale     <= i_cfg_data[17:0];
                REG_DAMPING_FACTOR: r_cfg.damping_factor <= i_cfg_data[16:0];
                REG_ORBITAL_GAIN:   r_cfg.orbital_gain   <= i_cfg_data[21:0];
                REG_ATTRACT_GAIN:   r_cfg.attract_gain   <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // Stage 1: offsets to the vortex and their magnitudes
    logic signed [33:0] n1_dx, n1_dy;
    logic               r1_vld, r2_vld, r3_vld;
    t_sq_side           r1_side, r2_side, r3_side;
    logic [63:0]        r2_sqx, r2_sqy, r3_sum;

    assign n1_dx = $signed({6'd0, r_cfg.vortex_x}) - 34'(i_in.pos_x);
    assign n1_dy = $signed({6'd0, r_cfg.vortex_y}) - 34'(i_in.pos_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // Stages 2 and 3: squares, then their sum
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_side.item <= i_in;
            r1_side.mx   <= n1_dx[33] ? 32'(-n1_dx) : 32'(n1_dx);
            r1_side.my   <= n1_dy[33] ? 32'(-n1_dy) : 32'(n1_dy);
            r1_side.sgx  <= n1_dx[33];
            r1_side.sgy  <= n1_dy[33];
            r2_sqx       <= r1_side.mx * r1_side.mx;
            r2_sqy       <= r1_side.my * r1_side.my;
            r2_side      <= r1_side;
            r3_sum       <= r2_sqx + r2_sqy;
            r3_side      <= r2_side;
        end
    end

    logic        sq_vld, dv_vld, fc_vld;
    logic [31:0] sq_root;
    t_sq_side    sq_side;
    t_unit       dv_unit;
    t_acc        fc_acc;

    vps_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r3_vld),
        .i_n     (r3_sum),
        .i_side  (r3_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    vps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (sq_vld),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_vld   (dv_vld),
        .o_unit  (dv_unit)
    );

    vps_force u_force (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_cfg   (r_cfg),
        .i_vld   (dv_vld),
        .i_unit  (dv_unit),
        .o_vld   (fc_vld),
        .o_acc   (fc_acc)
    );

    vps_integ #(
        .DISP_W (DISP_W),
        .DISP_H (DISP_H)
    ) u_integ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_cfg   (r_cfg),
        .i_vld   (fc_vld),
        .i_acc   (fc_acc),
        .o_vld   (o_valid),
        .o_out   (o_out)
    );

    // Wrapped positions stay on screen
    a_wrap_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_cfg.mode[MODE_WRAP] |->
            o_out.new_pos_x >= 0 && o_out.new_pos_x < DISP_W * 65536)
        else $error("wrapped x position off screen");

    a_wrap_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_cfg.mode[MODE_WRAP] |->
            o_out.new_pos_y >= 0 && o_out.new_pos_y < DISP_H * 65536)
        else $error("wrapped y position off screen");

    // An accepted request occupies the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r1_vld)
        else $error("accepted request lost at pipeline entry");

endmodule

`default_nettype wire

/* hw/rtl/vps_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module vps_isqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [63:0]        i_n,
    input  vps_pkg::t_sq_side  i_side,
    output logic               o_vld,
    output logic [31:0]        o_root,
    output vps_pkg::t_sq_side  o_side
);
    import vps_pkg::*;

    localparam int NS = 32;

    logic [63:0] r_rem  [1:NS];
    logic [31:0] r_root [1:NS];
    t_sq_side    r_side [1:NS];
    logic        r_vld  [1:NS];

    generate
        for (genvar k = 0; k < NS; k++) begin : g_stg
            localparam int BI = NS - 1 - k;
            logic [63:0] rem_in;
            logic [31:0] root_in;
            t_sq_side    side_in;
            logic        vld_in;
            logic [63:0] test;
            logic [64:0] diff;

            if (k == 0) begin : g_first
                assign rem_in  = i_n;
                assign root_in = '0;
                assign side_in = i_side;
                assign vld_in  = i_vld;
            end else begin : g_next
                assign rem_in  = r_rem[k];
                assign root_in = r_root[k];
                assign side_in = r_side[k];
                assign vld_in  = r_vld[k];
            end

            // trial subtract of (root + bit)^2 - root^2
            assign test = ({32'd0, root_in} << (BI + 1)) | (64'd1 << (2 * BI));
            assign diff = {1'b0, rem_in} - {1'b0, test};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k+1] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!diff[64]) begin
                        r_rem[k+1]  <= diff[63:0];
                        r_root[k+1] <= root_in | (32'd1 << BI);
                    end else begin
                        r_rem[k+1]  <= rem_in;
                        r_root[k+1] <= root_in;
                    end
                    r_side[k+1] <= side_in;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[NS];
    assign o_root = r_root[NS];
    assign o_side = r_side[NS];

endmodule

`default_nettype wire

/* hw/rtl/vps_div.sv */
// Pipelined restoring dividers for the inverse distance and the unit vector.
`default_nettype none

module vps_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [31:0]        i_root,
    input  vps_pkg::t_sq_side  i_side,
    output logic               o_vld,
    output vps_pkg::t_unit     o_unit
);
    import vps_pkg::*;

    localparam int NS = 33;
    localparam int NL = 3;   // lane 0 inverse, lane 1 x, lane 2 y
    localparam logic [31:0] ONE_Q = 32'd65536;

    // Entry stage: clamp distance and form numerators
    logic        r_e_vld;
    logic [31:0] r_e_dist;
    logic [63:0] r_e_num [NL];
    t_dv_side    r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_e_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_dist      <= (i_root < ONE_Q) ? ONE_Q : i_root;
            r_e_num[0]    <= 64'd1 << 48;
            r_e_num[1]    <= {16'd0, i_side.mx, 16'd0};
            r_e_num[2]    <= {16'd0, i_side.my, 16'd0};
            r_e_side.item <= i_side.item;
            r_e_side.sgx  <= i_side.sgx;
            r_e_side.sgy  <= i_side.sgy;
        end
    end

    logic [63:0] r_rem  [1:NS][NL];
    logic [32:0] r_q    [1:NS][NL];
    logic [31:0] r_dist [1:NS];
    t_dv_side    r_side [1:NS];
    logic        r_vld  [1:NS];

    generate
        for (genvar k = 0; k < NS; k++) begin : g_stg
            localparam int BI = NS - 1 - k;
            logic [63:0] rem_in [NL];
            logic [32:0] q_in   [NL];
            logic [31:0] dist_in;
            t_dv_side    side_in;
            logic        vld_in;
            logic [63:0] dsh;

            if (k == 0) begin : g_first
                assign rem_in  = r_e_num;
                assign q_in    = '{default: '0};
                assign dist_in = r_e_dist;
                assign side_in = r_e_side;
                assign vld_in  = r_e_vld;
            end else begin : g_next
                assign rem_in  = r_rem[k];
                assign q_in    = r_q[k];
                assign dist_in = r_dist[k];
                assign side_in = r_side[k];
                assign vld_in  = r_vld[k];
            end

            assign dsh = {32'd0, dist_in} << BI;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k+1] <= vld_in;
                end
            end

            // one quotient bit per lane
            always_ff @(posedge i_clk) begin
                logic [64:0] diff;
                if (i_en) begin
                    for (int l = 0; l < NL; l++) begin
                        diff = {1'b0, rem_in[l]} - {1'b0, dsh};
                        if (!diff[64]) begin
                            r_rem[k+1][l] <= diff[63:0];
                            r_q[k+1][l]   <= q_in[l] | (33'd1 << BI);
                        end else begin
                            r_rem[k+1][l] <= rem_in[l];
                            r_q[k+1][l]   <= q_in[l];
                        end
                    end
                    r_dist[k+1] <= dist_in;
                    r_side[k+1] <= side_in;
                end
            end
        end
    endgenerate

    // Output stage: apply signs to the unit vector
    logic signed [17:0] qx;
    logic signed [17:0] qy;
    logic               r_o_vld;
    t_unit              r_o_unit;

    assign qx = $signed(r_q[NS][1][17:0]);
    assign qy = $signed(r_q[NS][2][17:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_unit.item <= r_side[NS].item;
            r_o_unit.ux   <= r_side[NS].sgx ? -qx : qx;
            r_o_unit.uy   <= r_side[NS].sgy ? -qy : qy;
            r_o_unit.inv  <= r_q[NS][0];
        end
    end

    assign o_vld  = r_o_vld;
    assign o_unit = r_o_unit;

endmodule

`default_nettype wire

/* hw/rtl/vps_force.sv */
// Force stages: orbital and attraction terms, acceleration added to velocity.
`default_nettype none

module vps_force (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  vps_pkg::t_cfg   i_cfg,
    input  logic            i_vld,
    input  vps_pkg::t_unit  i_unit,
    output logic            o_vld,
    output vps_pkg::t_acc   o_acc
);
    import vps_pkg::*;

    logic r_vld [1:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 5; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[1] <= i_vld;
            for (int s = 2; s <= 5; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // Stage 1: orbital gain over distance
    logic [54:0] n1_prod;
    logic [22:0] r1_ob;
    t_unit       r1_u;
    assign n1_prod = i_cfg.orbital_gain * i_unit.inv;

    // Stage 2: attraction scale and tangential term
    logic [43:0] n2_kp;
    logic [40:0] n2_tp;
    logic [27:0] r2_k1;
    logic [24:0] r2_t;
    t_unit       r2_u;
    assign n2_kp = i_cfg.attract_gain * (24'd65536 + {1'b0, r1_ob});
    assign n2_tp = r1_ob * i_cfg.step_scale;

    // Stage 3: step-scaled products
    logic [45:0]        n3_kp;
    logic signed [18:0] s_step;
    logic signed [36:0] r3_uxs;
    logic signed [36:0] r3_uys;
    logic signed [43:0] r3_uxt;
    logic signed [43:0] r3_uyt;
    logic [29:0]        r3_k;
    t_unit              r3_u;
    assign n3_kp  = r2_k1 * i_cfg.step_scale;
    assign s_step = $signed({1'b0, i_cfg.step_scale});

    // Stage 4: select radial or radial plus tangential
    logic signed [48:0] n4_fx;
    logic signed [48:0] n4_fy;
    logic signed [48:0] r4_fx;
    logic signed [48:0] r4_fy;
    t_in                r4_item;

    always_comb begin
        if (i_cfg.mode[MODE_ATTRACT]) begin
            n4_fx = r3_u.ux * $signed({1'b0, r3_k});
            n4_fy = r3_u.uy * $signed({1'b0, r3_k});
        end else begin
            n4_fx = 49'(r3_uxs) - 49'(r3_uyt);
            n4_fy = 49'(r3_uys) + 49'(r3_uxt);
        end
    end

    // Stage 5: floor back to Q16.16 and add velocity
    t_acc r5_acc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ob   <= n1_prod[54:32];
            r1_u    <= i_unit;
            r2_k1   <= n2_kp[43:16];
            r2_t    <= n2_tp[40:16];
            r2_u    <= r1_u;
            r3_k    <= n3_kp[45:16];
            r3_uxs  <= r2_u.ux * s_step;
            r3_uys  <= r2_u.uy * s_step;
            r3_uxt  <= r2_u.ux * $signed({1'b0, r2_t});
            r3_uyt  <= r2_u.uy * $signed({1'b0, r2_t});
            r3_u    <= r2_u;
            r4_fx   <= n4_fx;
            r4_fy   <= n4_fy;
            r4_item <= r3_u.item;
            r5_acc.item  <= r4_item;
            r5_acc.sum_x <= 33'(r4_item.vel_x) + $signed(r4_fx[48:16]);
            r5_acc.sum_y <= 33'(r4_item.vel_y) + $signed(r4_fy[48:16]);
        end
    end

    assign o_vld = r_vld[5];
    assign o_acc = r5_acc;

endmodule

`default_nettype wire

/* hw/rtl/vps_integ.sv */
// Integration stages: damping, position update, wrap or saturate.
`default_nettype none

module vps_integ #(
    parameter int DISP_W = vps_pkg::DISP_W_DEF,
    parameter int DISP_H = vps_pkg::DISP_H_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  vps_pkg::t_cfg  i_cfg,
    input  logic           i_vld,
    input  vps_pkg::t_acc  i_acc,
    output logic           o_vld,
    output vps_pkg::t_out  o_out
);
    import vps_pkg::*;

    localparam int MAXWH = (DISP_W > DISP_H) ? DISP_W : DISP_H;
    localparam int RW    = $clog2(2 * MAXWH + 1);
    // offsets that make the pixel part non-negative, multiples of the size
    localparam int OFF_W = DISP_W * (((1 << 19) + DISP_W - 1) / DISP_W);
    localparam int OFF_H = DISP_H * (((1 << 19) + DISP_H - 1) / DISP_H);
    localparam logic [32:0] RCP_W = 33'((64'd1 << 32) / DISP_W);
    localparam logic [32:0] RCP_H = 33'((64'd1 << 32) / DISP_H);
    localparam logic [21:0] W22   = 22'(DISP_W);
    localparam logic [21:0] H22   = 22'(DISP_H);
    localparam logic [RW-1:0] WRW = RW'(DISP_W);
    localparam logic [RW-1:0] HRW = RW'(DISP_H);
    localparam logic signed [35:0] MAXV = 36'sh07FFFFFFF;
    localparam logic signed [35:0] MINV = -36'sh080000000;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > MAXV) begin
            return 32'sh7FFFFFFF;
        end else if (v < MINV) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    logic r_vld [1:7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 7; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[1] <= i_vld;
            for (int s = 2; s <= 7; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    logic signed [17:0] s_damp;
    logic signed [18:0] s_step;
    assign s_damp = $signed({1'b0, i_cfg.damping_factor});
    assign s_step = $signed({1'b0, i_cfg.step_scale});

    // Stage 1: damping product
    logic signed [50:0] r1_pvx, r1_pvy;
    t_in                r1_item;
    // Stage 2: saturated velocity
    logic signed [31:0] r2_nvx, r2_nvy;
    t_in                r2_item;
    // Stage 3: velocity times step
    logic signed [50:0] r3_dpx, r3_dpy;
    logic signed [31:0] r3_nvx, r3_nvy;
    t_in                r3_item;
    // Stage 4: raw position
    logic signed [35:0] r4_npx, r4_npy;
    logic signed [31:0] r4_nvx, r4_nvy;
    logic               r4_last;
    // Stage 5: saturated position and reciprocal product
    logic [20:0]        n5_hx, n5_hy;
    logic [20:0]        r5_hx, r5_hy;
    logic [53:0]        r5_qpx, r5_qpy;
    logic [15:0]        r5_lox, r5_loy;
    logic signed [31:0] r5_satx, r5_saty;
    logic signed [31:0] r5_nvx, r5_nvy;
    logic               r5_last;
    // Stage 6: partial remainder
    logic [43:0]        n6_qwx, n6_qwy;
    logic [21:0]        n6_rx, n6_ry;
    logic [RW-1:0]      r6_rx, r6_ry;
    logic [15:0]        r6_lox, r6_loy;
    logic signed [31:0] r6_satx, r6_saty;
    logic signed [31:0] r6_nvx, r6_nvy;
    logic               r6_last;
    // Stage 7: output register
    logic [RW-1:0]      n7_rx, n7_ry;
    t_out               r7_out;

    assign n5_hx = 21'($signed({r4_npx[35], r4_npx[35:16]}) + 21'(OFF_W));
    assign n5_hy = 21'($signed({r4_npy[35], r4_npy[35:16]}) + 21'(OFF_H));

    assign n6_qwx = r5_qpx[53:32] * W22;
    assign n6_qwy = r5_qpy[53:32] * H22;
    assign n6_rx  = {1'b0, r5_hx} - n6_qwx[21:0];
    assign n6_ry  = {1'b0, r5_hy} - n6_qwy[21:0];

    assign n7_rx = (r6_rx >= WRW) ? r6_rx - WRW : r6_rx;
    assign n7_ry = (r6_ry >= HRW) ? r6_ry - HRW : r6_ry;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pvx  <= i_acc.sum_x * s_damp;
            r1_pvy  <= i_acc.sum_y * s_damp;
            r1_item <= i_acc.item;

            r2_nvx  <= sat32(36'($signed(r1_pvx[50:16])));
            r2_nvy  <= sat32(36'($signed(r1_pvy[50:16])));
            r2_item <= r1_item;

            r3_dpx  <= r2_nvx * s_step;
            r3_dpy  <= r2_nvy * s_step;
            r3_nvx  <= r2_nvx;
            r3_nvy  <= r2_nvy;
            r3_item <= r2_item;

            r4_npx  <= 36'(r3_item.pos_x) + 36'($signed(r3_dpx[50:16]));
            r4_npy  <= 36'(r3_item.pos_y) + 36'($signed(r3_dpy[50:16]));
            r4_nvx  <= r3_nvx;
            r4_nvy  <= r3_nvy;
            r4_last <= r3_item.last_in;

            r5_hx   <= n5_hx;
            r5_hy   <= n5_hy;
            r5_qpx  <= n5_hx * RCP_W;
            r5_qpy  <= n5_hy * RCP_H;
            r5_lox  <= r4_npx[15:0];
            r5_loy  <= r4_npy[15:0];
            r5_satx <= sat32(r4_npx);
            r5_saty <= sat32(r4_npy);
            r5_nvx  <= r4_nvx;
            r5_nvy  <= r4_nvy;
            r5_last <= r4_last;

            r6_rx   <= n6_rx[RW-1:0];
            r6_ry   <= n6_ry[RW-1:0];
            r6_lox  <= r5_lox;
            r6_loy  <= r5_loy;
            r6_satx <= r5_satx;
            r6_saty <= r5_saty;
            r6_nvx  <= r5_nvx;
            r6_nvy  <= r5_nvy;
            r6_last <= r5_last;

            if (i_cfg.mode[MODE_WRAP]) begin
                r7_out.new_pos_x <= $signed(32'({n7_rx, r6_lox}));
                r7_out.new_pos_y <= $signed(32'({n7_ry, r6_loy}));
            end else begin
                r7_out.new_pos_x <= r6_satx;
                r7_out.new_pos_y <= r6_saty;
            end
            r7_out.new_vel_x <= r6_nvx;
            r7_out.new_vel_y <= r6_nvy;
            r7_out.last_out  <= r6_last;
        end
    end

    assign o_vld = r_vld[7];
    assign o_out = r7_out;

endmodule

`default_nettype wire
